// ===== design/wtc_pkg.sv =====
package wtc_pkg;

    // Field widths fixed by the interface
    localparam int FUNC_W    = 3;
    localparam int SUB_W     = 4;
    localparam int MODE_W    = 3;
    localparam int SHOWN_W   = 16;
    localparam int MSG_W     = 2;
    localparam int OUTCOME_W = 2;
    localparam int STEP_W    = 12;
    localparam int HOLD_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [FUNC_W-1:0]    func_t;
    typedef logic [MSG_W-1:0]     msg_t;
    typedef logic [OUTCOME_W-1:0] outcome_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Modes
    localparam mode_t MODE_IDLE  = 3'd0;
    localparam mode_t MODE_SET   = 3'd1;
    localparam mode_t MODE_RUN   = 3'd2;
    localparam mode_t MODE_PAUSE = 3'd3;
    localparam mode_t MODE_STAT  = 3'd4;

    // Events
    localparam func_t FUNC_INC   = 3'd0;
    localparam func_t FUNC_DEC   = 3'd1;
    localparam func_t FUNC_START = 3'd2;
    localparam func_t FUNC_ABORT = 3'd3;
    localparam func_t FUNC_TICK  = 3'd4;

    // Display messages
    localparam msg_t MSG_NONE       = 2'd0;
    localparam msg_t MSG_SET_TIME   = 2'd1;
    localparam msg_t MSG_PAUSED     = 2'd2;
    localparam msg_t MSG_PRODUCTIVE = 2'd3;

    // Event outcomes
    localparam outcome_t OUT_IGNORED    = 2'd0;
    localparam outcome_t OUT_HANDLED    = 2'd1;
    localparam outcome_t OUT_TRANSITION = 2'd2;

    // Register indexes
    localparam cfg_idx_t CFG_STEP       = 2'd0;
    localparam cfg_idx_t CFG_BEEP_SUB   = 2'd1;
    localparam cfg_idx_t CFG_COUNT_SUB  = 2'd2;
    localparam cfg_idx_t CFG_STAT_HOLD  = 2'd3;

    // Register reset values
    localparam logic [STEP_W-1:0] STEP_RST       = 12'd60;
    localparam logic [SUB_W-1:0]  BEEP_SUB_RST   = 4'd5;
    localparam logic [SUB_W-1:0]  COUNT_SUB_RST  = 4'd10;
    localparam logic [HOLD_W-1:0] STAT_HOLD_RST  = 8'd40;

endpackage

// ===== design/work_timer_controller.sv =====
// Five-mode countdown work timer (idle, time set, countdown, pause, statistics).
// Each event beat on the s_ channel gives exactly one result beat on the m_
// channel. An event is held in an input register, the mode update and its
// exit/entry actions are worked out combinationally, and the result lands in
// an output register: a result passes the input register and then the output
// register on its way to the m_ channel, and one event is taken every cycle
// while m_ready is high. Registers are written through the cfg_ channel, which
// is always ready; write them only while no event is in flight. TIME_WIDTH sets
// the width of the set, elapsed and productive second counters, which all
// saturate; shown_seconds saturates at 65535.
module work_timer_controller #(
    parameter int TIME_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [wtc_pkg::FUNC_W-1:0]        s_func,
    input  logic [wtc_pkg::SUB_W-1:0]         s_sub_tick,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [wtc_pkg::MODE_W-1:0]        m_mode,
    output logic [wtc_pkg::SHOWN_W-1:0]       m_shown_seconds,
    output logic [wtc_pkg::MSG_W-1:0]         m_message,
    output logic                              m_beep,
    output logic [wtc_pkg::OUTCOME_W-1:0]     m_outcome,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wtc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wtc_pkg::CFG_DAT_W-1:0]     cfg_data
);

    localparam int SW = (TIME_WIDTH > wtc_pkg::STEP_W) ? TIME_WIDTH : wtc_pkg::STEP_W;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};
    localparam logic [wtc_pkg::HOLD_W-1:0] CNT_MAX = {wtc_pkg::HOLD_W{1'b1}};

    // Configuration
    logic [wtc_pkg::STEP_W-1:0] step_reg;
    logic [wtc_pkg::SUB_W-1:0]  beep_sub_reg;
    logic [wtc_pkg::SUB_W-1:0]  count_sub_reg;
    logic [wtc_pkg::HOLD_W-1:0] hold_reg;

    // Input stage
    logic                       in_valid_reg;
    wtc_pkg::func_t             func_reg;
    logic [wtc_pkg::SUB_W-1:0]  sub_reg;

    // Timer state
    wtc_pkg::mode_t             mode_reg, mode_next;
    logic [TIME_WIDTH-1:0]      set_reg, set_next;
    logic [TIME_WIDTH-1:0]      run_reg, run_next;
    logic [TIME_WIDTH-1:0]      prod_reg, prod_next;
    logic [wtc_pkg::HOLD_W-1:0] cnt_reg, cnt_next;

    // Result stage
    logic                       out_valid_reg;
    wtc_pkg::mode_t             out_mode_reg;
    logic [wtc_pkg::SHOWN_W-1:0] out_shown_reg;
    wtc_pkg::msg_t              out_msg_reg;
    logic                       out_beep_reg;
    wtc_pkg::outcome_t          out_outcome_reg;

    logic                       advance;
    wtc_pkg::mode_t             cur;
    wtc_pkg::outcome_t          res;
    logic                       beep;
    wtc_pkg::msg_t              msg;
    logic [TIME_WIDTH-1:0]      shown_t;
    logic [wtc_pkg::SHOWN_W-1:0] shown16;
    logic [TIME_WIDTH-1:0]      set_plus;
    logic                       set_ge_step;
    logic [TIME_WIDTH-1:0]      set_minus;
    logic [TIME_WIDTH-1:0]      set_dec1;
    logic [TIME_WIDTH-1:0]      run_inc;
    logic [wtc_pkg::HOLD_W-1:0] cnt_inc;

    function automatic logic [TIME_WIDTH-1:0] sat_add(
        input logic [SW-1:0] a,
        input logic [SW-1:0] b
    );
        logic [SW:0] s;
        s = (SW+1)'(a) + (SW+1)'(b);
        if (s > (SW+1)'(TIME_MAX)) begin
            return TIME_MAX;
        end
        return TIME_WIDTH'(s);
    endfunction

    // Pipeline handshake
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= wtc_pkg::STEP_RST;
            beep_sub_reg  <= wtc_pkg::BEEP_SUB_RST;
            count_sub_reg <= wtc_pkg::COUNT_SUB_RST;
            hold_reg      <= wtc_pkg::STAT_HOLD_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                wtc_pkg::CFG_STEP:      step_reg      <= cfg_data;
                wtc_pkg::CFG_BEEP_SUB:  beep_sub_reg  <= cfg_data[wtc_pkg::SUB_W-1:0];
                wtc_pkg::CFG_COUNT_SUB: count_sub_reg <= cfg_data[wtc_pkg::SUB_W-1:0];
                wtc_pkg::CFG_STAT_HOLD: hold_reg      <= cfg_data[wtc_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            sub_reg  <= s_sub_tick;
        end
    end

    // Shared arithmetic on the current state
    assign set_plus    = sat_add(SW'(set_reg), SW'(step_reg));
    assign set_ge_step = SW'(set_reg) >= SW'(step_reg);
    assign set_minus   = TIME_WIDTH'(SW'(set_reg) - SW'(step_reg));
    assign set_dec1    = (set_reg != '0) ? set_reg - TIME_WIDTH'(1) : set_reg;
    assign run_inc     = (run_reg == TIME_MAX) ? run_reg : run_reg + TIME_WIDTH'(1);
    assign cnt_inc     = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + wtc_pkg::HOLD_W'(1);

    always_comb begin
        cur       = (mode_reg > wtc_pkg::MODE_STAT) ? wtc_pkg::MODE_IDLE : mode_reg;
        mode_next = cur;
        set_next  = set_reg;
        run_next  = run_reg;
        prod_next = prod_reg;
        cnt_next  = cnt_reg;
        res       = wtc_pkg::OUT_IGNORED;
        beep      = 1'b0;

        case (cur)
            wtc_pkg::MODE_SET: begin
                if (func_reg == wtc_pkg::FUNC_INC) begin
                    set_next = set_plus;
                    res      = wtc_pkg::OUT_HANDLED;
                end else if (func_reg == wtc_pkg::FUNC_DEC) begin
                    if (set_ge_step) begin
                        set_next = set_minus;
                        res      = wtc_pkg::OUT_HANDLED;
                    end
                end else if (func_reg == wtc_pkg::FUNC_START) begin
                    if (set_ge_step) begin
                        mode_next = wtc_pkg::MODE_RUN;
                        res       = wtc_pkg::OUT_TRANSITION;
                    end
                end else if (func_reg == wtc_pkg::FUNC_ABORT) begin
                    mode_next = wtc_pkg::MODE_IDLE;
                    res       = wtc_pkg::OUT_TRANSITION;
                end
            end
            wtc_pkg::MODE_RUN: begin
                if (func_reg == wtc_pkg::FUNC_START) begin
                    mode_next = wtc_pkg::MODE_PAUSE;
                    res       = wtc_pkg::OUT_TRANSITION;
                end else if (func_reg == wtc_pkg::FUNC_ABORT) begin
                    mode_next = wtc_pkg::MODE_IDLE;
                    res       = wtc_pkg::OUT_TRANSITION;
                end else if (func_reg == wtc_pkg::FUNC_TICK && sub_reg == count_sub_reg) begin
                    set_next = set_dec1;
                    run_next = run_inc;
                    if (set_dec1 == '0) begin
                        mode_next = wtc_pkg::MODE_IDLE;
                        res       = wtc_pkg::OUT_TRANSITION;
                    end else begin
                        res = wtc_pkg::OUT_HANDLED;
                    end
                end
            end
            wtc_pkg::MODE_PAUSE: begin
                if (func_reg == wtc_pkg::FUNC_INC) begin
                    set_next  = set_plus;
                    mode_next = wtc_pkg::MODE_SET;
                    res       = wtc_pkg::OUT_TRANSITION;
                end else if (func_reg == wtc_pkg::FUNC_DEC) begin
                    if (set_ge_step) begin
                        set_next  = set_minus;
                        mode_next = wtc_pkg::MODE_SET;
                        res       = wtc_pkg::OUT_TRANSITION;
                    end
                end else if (func_reg == wtc_pkg::FUNC_START) begin
                    mode_next = wtc_pkg::MODE_RUN;
                    res       = wtc_pkg::OUT_TRANSITION;
                end else if (func_reg == wtc_pkg::FUNC_ABORT) begin
                    mode_next = wtc_pkg::MODE_IDLE;
                    res       = wtc_pkg::OUT_TRANSITION;
                end
            end
            wtc_pkg::MODE_STAT: begin
                if (func_reg == wtc_pkg::FUNC_TICK) begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= hold_reg) begin
                        cnt_next  = '0;
                        mode_next = wtc_pkg::MODE_IDLE;
                        res       = wtc_pkg::OUT_TRANSITION;
                    end
                end
            end
            default: begin
                if (func_reg == wtc_pkg::FUNC_INC) begin
                    set_next  = set_plus;
                    mode_next = wtc_pkg::MODE_SET;
                    res       = wtc_pkg::OUT_TRANSITION;
                end else if (func_reg == wtc_pkg::FUNC_START) begin
                    mode_next = wtc_pkg::MODE_STAT;
                    res       = wtc_pkg::OUT_TRANSITION;
                end else if (func_reg == wtc_pkg::FUNC_TICK && sub_reg == beep_sub_reg) begin
                    beep = 1'b1;
                    res  = wtc_pkg::OUT_HANDLED;
                end
            end
        endcase

        // Exit action of the old mode, then entry action of the new one
        if (res == wtc_pkg::OUT_TRANSITION) begin
            if (cur == wtc_pkg::MODE_RUN) begin
                prod_next = sat_add(SW'(prod_reg), SW'(run_next));
                run_next  = '0;
            end
            if (mode_next == wtc_pkg::MODE_IDLE) begin
                set_next = '0;
                run_next = '0;
            end
        end

        shown_t = (mode_next == wtc_pkg::MODE_STAT) ? prod_next : set_next;

        case (mode_next)
            wtc_pkg::MODE_IDLE:  msg = wtc_pkg::MSG_SET_TIME;
            wtc_pkg::MODE_PAUSE: msg = wtc_pkg::MSG_PAUSED;
            wtc_pkg::MODE_STAT:  msg = wtc_pkg::MSG_PRODUCTIVE;
            default:             msg = wtc_pkg::MSG_NONE;
        endcase
    end

    generate
        if (TIME_WIDTH > wtc_pkg::SHOWN_W) begin : g_shown_sat
            assign shown16 = (|shown_t[TIME_WIDTH-1:wtc_pkg::SHOWN_W]) ? '1
                           : shown_t[wtc_pkg::SHOWN_W-1:0];
        end else begin : g_shown_ext
            assign shown16 = wtc_pkg::SHOWN_W'(shown_t);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= wtc_pkg::MODE_IDLE;
            set_reg  <= '0;
            run_reg  <= '0;
            prod_reg <= '0;
            cnt_reg  <= '0;
        end else if (advance) begin
            mode_reg <= mode_next;
            set_reg  <= set_next;
            run_reg  <= run_next;
            prod_reg <= prod_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_mode_reg    <= mode_next;
            out_shown_reg   <= shown16;
            out_msg_reg     <= msg;
            out_beep_reg    <= beep;
            out_outcome_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_mode          = out_mode_reg;
    assign m_shown_seconds = out_shown_reg;
    assign m_message       = out_msg_reg;
    assign m_beep          = out_beep_reg;
    assign m_outcome       = out_outcome_reg;

    // Elapsed time only lives while counting down
    a_run_only_in_countdown: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != wtc_pkg::MODE_RUN |-> run_reg == '0)
        else $error("elapsed count left non-zero outside countdown");

    // Idle always shows a cleared set time
    a_idle_clears_set: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == wtc_pkg::MODE_IDLE |-> set_reg == '0)
        else $error("set time not cleared in idle");

    // The beat loaded into the result stage carries the new mode
    a_result_tracks_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_mode_reg == mode_reg)
        else $error("result mode differs from stored mode");

    // A beep is only raised by an idle tick
    a_beep_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_beep_reg |->
            out_mode_reg == wtc_pkg::MODE_IDLE && out_outcome_reg == wtc_pkg::OUT_HANDLED)
        else $error("beep outside an idle tick");

    // An ignored event leaves the mode where it was
    a_ignored_holds_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res == wtc_pkg::OUT_IGNORED && mode_reg <= wtc_pkg::MODE_STAT
            |=> mode_reg == $past(mode_reg))
        else $error("ignored event changed the mode");

endmodule

// ===== verif/work_timer_controller_tb.sv =====
module work_timer_controller_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_QUOTA   = 80;
    localparam int PRINT_CAP     = 100;

    typedef logic [wtc_pkg::SUB_W-1:0]     sub_t;
    typedef logic [wtc_pkg::CFG_DAT_W-1:0] cfg_data_t;

    typedef struct packed {
        wtc_pkg::mode_t                mode;
        logic [wtc_pkg::SHOWN_W-1:0]   shown;
        wtc_pkg::msg_t                 message;
        logic                          beep;
        wtc_pkg::outcome_t             outcome;
    } timer_out_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    wtc_pkg::func_t                s_func;
    sub_t                          s_sub_tick;
    logic                          m_valid;
    logic                          m_ready;
    wtc_pkg::mode_t                m_mode;
    logic [wtc_pkg::SHOWN_W-1:0]   m_shown_seconds;
    wtc_pkg::msg_t                 m_message;
    logic                          m_beep;
    wtc_pkg::outcome_t             m_outcome;
    logic                          cfg_valid;
    logic                          cfg_ready;
    wtc_pkg::cfg_idx_t             cfg_index;
    cfg_data_t                     cfg_data;

    // Own copy of the timer state and its registers
    wtc_pkg::mode_t                tm_mode;
    logic [15:0]                   tm_set;
    logic [15:0]                   tm_run;
    logic [15:0]                   tm_prod;
    logic [7:0]                    tm_stat;
    logic [wtc_pkg::STEP_W-1:0]    cfg_step;
    sub_t                          cfg_beep;
    sub_t                          cfg_count;
    logic [wtc_pkg::HOLD_W-1:0]    cfg_hold;

    timer_out_t            due_results[$];
    int                    mismatches;
    int                    results_seen;
    int                    events_sent;
    int                    mode_changes;
    int                    beeps_due;
    int                    settings_used;
    int                    cycle_count;
    bit                    quiet;
    bit                    long_sets;

    work_timer_controller dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_sub_tick      (s_sub_tick),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mode          (m_mode),
        .m_shown_seconds (m_shown_seconds),
        .m_message       (m_message),
        .m_beep          (m_beep),
        .m_outcome       (m_outcome),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("TEST FAILED");
        $finish;
    end

    function automatic int draw_wait();
        if (quiet || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [15:0] sat_sum(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    task automatic reset_timer_model();
        tm_mode   = wtc_pkg::MODE_IDLE;
        tm_set    = '0;
        tm_run    = '0;
        tm_prod   = '0;
        tm_stat   = '0;
        cfg_step  = wtc_pkg::STEP_RST;
        cfg_beep  = wtc_pkg::BEEP_SUB_RST;
        cfg_count = wtc_pkg::COUNT_SUB_RST;
        cfg_hold  = wtc_pkg::STAT_HOLD_RST;
    endtask

    // Advance the timer by one event and return what the display should get
    function automatic timer_out_t step_timer(input wtc_pkg::func_t f, input sub_t sub);
        wtc_pkg::mode_t    cur;
        wtc_pkg::mode_t    nxt;
        wtc_pkg::outcome_t res;
        logic              bp;
        logic [15:0]       step16;
        timer_out_t        r;
        step16 = {4'd0, cfg_step};
        cur    = (tm_mode > wtc_pkg::MODE_STAT) ? wtc_pkg::MODE_IDLE : tm_mode;
        nxt    = cur;
        res    = wtc_pkg::OUT_IGNORED;
        bp     = 1'b0;
        case (cur)
            wtc_pkg::MODE_SET: begin
                if (f == wtc_pkg::FUNC_INC) begin
                    tm_set = sat_sum(tm_set, step16);
                    res    = wtc_pkg::OUT_HANDLED;
                end else if (f == wtc_pkg::FUNC_DEC) begin
                    if (tm_set >= step16) begin
                        tm_set = tm_set - step16;
                        res    = wtc_pkg::OUT_HANDLED;
                    end
                end else if (f == wtc_pkg::FUNC_START) begin
                    if (tm_set >= step16) begin
                        nxt = wtc_pkg::MODE_RUN;
                        res = wtc_pkg::OUT_TRANSITION;
                    end
                end else if (f == wtc_pkg::FUNC_ABORT) begin
                    nxt = wtc_pkg::MODE_IDLE;
                    res = wtc_pkg::OUT_TRANSITION;
                end
            end
            wtc_pkg::MODE_RUN: begin
                if (f == wtc_pkg::FUNC_START) begin
                    nxt = wtc_pkg::MODE_PAUSE;
                    res = wtc_pkg::OUT_TRANSITION;
                end else if (f == wtc_pkg::FUNC_ABORT) begin
                    nxt = wtc_pkg::MODE_IDLE;
                    res = wtc_pkg::OUT_TRANSITION;
                end else if (f == wtc_pkg::FUNC_TICK && sub == cfg_count) begin
                    if (tm_set != 16'd0)
                        tm_set = tm_set - 16'd1;
                    tm_run = sat_sum(tm_run, 16'd1);
                    if (tm_set == 16'd0) begin
                        nxt = wtc_pkg::MODE_IDLE;
                        res = wtc_pkg::OUT_TRANSITION;
                    end else begin
                        res = wtc_pkg::OUT_HANDLED;
                    end
                end
            end
            wtc_pkg::MODE_PAUSE: begin
                if (f == wtc_pkg::FUNC_INC) begin
                    tm_set = sat_sum(tm_set, step16);
                    nxt    = wtc_pkg::MODE_SET;
                    res    = wtc_pkg::OUT_TRANSITION;
                end else if (f == wtc_pkg::FUNC_DEC) begin
                    if (tm_set >= step16) begin
                        tm_set = tm_set - step16;
                        nxt    = wtc_pkg::MODE_SET;
                        res    = wtc_pkg::OUT_TRANSITION;
                    end
                end else if (f == wtc_pkg::FUNC_START) begin
                    nxt = wtc_pkg::MODE_RUN;
                    res = wtc_pkg::OUT_TRANSITION;
                end else if (f == wtc_pkg::FUNC_ABORT) begin
                    nxt = wtc_pkg::MODE_IDLE;
                    res = wtc_pkg::OUT_TRANSITION;
                end
            end
            wtc_pkg::MODE_STAT: begin
                if (f == wtc_pkg::FUNC_TICK) begin
                    if (tm_stat < 8'd255)
                        tm_stat = tm_stat + 8'd1;
                    if (tm_stat >= cfg_hold) begin
                        tm_stat = '0;
                        nxt     = wtc_pkg::MODE_IDLE;
                        res     = wtc_pkg::OUT_TRANSITION;
                    end
                end
            end
            default: begin
                if (f == wtc_pkg::FUNC_INC) begin
                    tm_set = sat_sum(tm_set, step16);
                    nxt    = wtc_pkg::MODE_SET;
                    res    = wtc_pkg::OUT_TRANSITION;
                end else if (f == wtc_pkg::FUNC_START) begin
                    nxt = wtc_pkg::MODE_STAT;
                    res = wtc_pkg::OUT_TRANSITION;
                end else if (f == wtc_pkg::FUNC_TICK && sub == cfg_beep) begin
                    bp  = 1'b1;
                    res = wtc_pkg::OUT_HANDLED;
                end
            end
        endcase

        // Exit action of the old mode, then entry action of the new one
        if (res == wtc_pkg::OUT_TRANSITION) begin
            if (cur == wtc_pkg::MODE_RUN) begin
                tm_prod = sat_sum(tm_prod, tm_run);
                tm_run  = '0;
            end
            if (nxt == wtc_pkg::MODE_IDLE) begin
                tm_set = '0;
                tm_run = '0;
            end
        end
        tm_mode = nxt;

        r.mode    = nxt;
        r.shown   = (nxt == wtc_pkg::MODE_STAT) ? tm_prod : tm_set;
        r.beep    = bp;
        r.outcome = res;
        case (nxt)
            wtc_pkg::MODE_IDLE:  r.message = wtc_pkg::MSG_SET_TIME;
            wtc_pkg::MODE_PAUSE: r.message = wtc_pkg::MSG_PAUSED;
            wtc_pkg::MODE_STAT:  r.message = wtc_pkg::MSG_PRODUCTIVE;
            default:             r.message = wtc_pkg::MSG_NONE;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[cycle %0d] mismatch on %s: got %0d, expected %0d",
                     cycle_count, what, got, want);
    endtask

    task automatic check_result();
        timer_out_t want;
        results_seen++;
        if (due_results.size() == 0) begin
            report_mismatch("result beat with nothing due", 32'(m_mode), 32'd0);
        end else begin
            want = due_results.pop_front();
            if (m_mode !== want.mode)
                report_mismatch("mode", 32'(m_mode), 32'(want.mode));
            if (m_shown_seconds !== want.shown)
                report_mismatch("shown_seconds", 32'(m_shown_seconds), 32'(want.shown));
            if (m_message !== want.message)
                report_mismatch("message", 32'(m_message), 32'(want.message));
            if (m_beep !== want.beep)
                report_mismatch("beep", 32'(m_beep), 32'(want.beep));
            if (m_outcome !== want.outcome)
                report_mismatch("outcome", 32'(m_outcome), 32'(want.outcome));
        end
    endtask

    // Result side: drop m_ready for a randomly drawn stall, if any, then take one beat
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = draw_wait();
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            check_result();
            @(negedge aclk);
        end
    end

    // Called and left at a falling edge; valid stays high into the next call
    task automatic send_event(input wtc_pkg::func_t f, input sub_t sub);
        int         gap;
        timer_out_t r;
        gap = draw_wait();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_func     <= f;
        s_sub_tick <= sub;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = step_timer(f, sub);
        due_results.push_back(r);
        events_sent++;
        if (r.outcome == wtc_pkg::OUT_TRANSITION)
            mode_changes++;
        if (r.beep)
            beeps_due++;
        @(negedge aclk);
    endtask

    // Hold the sender until every due result has come back
    task automatic settle();
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input wtc_pkg::cfg_idx_t idx, input cfg_data_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            wtc_pkg::CFG_STEP:      cfg_step  = data[wtc_pkg::STEP_W-1:0];
            wtc_pkg::CFG_BEEP_SUB:  cfg_beep  = data[wtc_pkg::SUB_W-1:0];
            wtc_pkg::CFG_COUNT_SUB: cfg_count = data[wtc_pkg::SUB_W-1:0];
            wtc_pkg::CFG_STAT_HOLD: cfg_hold  = data[wtc_pkg::HOLD_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic write_all(input cfg_data_t step, input cfg_data_t bsub,
                             input cfg_data_t csub, input cfg_data_t hold);
        settle();
        write_reg(wtc_pkg::CFG_STEP, step);
        write_reg(wtc_pkg::CFG_BEEP_SUB, bsub);
        write_reg(wtc_pkg::CFG_COUNT_SUB, csub);
        write_reg(wtc_pkg::CFG_STAT_HOLD, hold);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly sensible events for the current mode, with some noise mixed in
    task automatic pick_event(output wtc_pkg::func_t f, output sub_t sub);
        int roll;
        roll = $urandom_range(0, 99);
        sub  = sub_t'($urandom_range(0, 15));
        f    = wtc_pkg::func_t'($urandom_range(0, 7));
        case (tm_mode)
            wtc_pkg::MODE_IDLE: begin
                if (roll < 45)
                    f = wtc_pkg::FUNC_INC;
                else if (roll < 58)
                    f = wtc_pkg::FUNC_START;
                else if (roll < 85) begin
                    f = wtc_pkg::FUNC_TICK;
                    if (roll < 72)
                        sub = cfg_beep;
                end
            end
            wtc_pkg::MODE_SET: begin
                if (long_sets) begin
                    if (roll < 88)
                        f = wtc_pkg::FUNC_INC;
                    else if (roll < 91)
                        f = wtc_pkg::FUNC_DEC;
                    else if (roll < 98)
                        f = wtc_pkg::FUNC_START;
                    else
                        f = wtc_pkg::FUNC_ABORT;
                end else begin
                    if (roll < 40)
                        f = wtc_pkg::FUNC_INC;
                    else if (roll < 60)
                        f = wtc_pkg::FUNC_DEC;
                    else if (roll < 88)
                        f = wtc_pkg::FUNC_START;
                    else if (roll < 94)
                        f = wtc_pkg::FUNC_ABORT;
                end
            end
            wtc_pkg::MODE_RUN: begin
                if (roll < 65) begin
                    f   = wtc_pkg::FUNC_TICK;
                    sub = cfg_count;
                end else if (roll < 75)
                    f = wtc_pkg::FUNC_TICK;
                else if (roll < 85)
                    f = wtc_pkg::FUNC_START;
                else if (roll < 89)
                    f = wtc_pkg::FUNC_ABORT;
            end
            wtc_pkg::MODE_PAUSE: begin
                if (roll < 30)
                    f = wtc_pkg::FUNC_START;
                else if (roll < 55)
                    f = wtc_pkg::FUNC_INC;
                else if (roll < 75)
                    f = wtc_pkg::FUNC_DEC;
                else if (roll < 85)
                    f = wtc_pkg::FUNC_ABORT;
            end
            default: begin
                if (roll < 80)
                    f = wtc_pkg::FUNC_TICK;
            end
        endcase
    endtask

    task automatic test_idle_events();
        int c;
        send_event(wtc_pkg::FUNC_TICK, wtc_pkg::BEEP_SUB_RST);
        send_event(wtc_pkg::FUNC_TICK, 4'd15);
        send_event(wtc_pkg::FUNC_DEC, 4'd0);
        send_event(wtc_pkg::FUNC_ABORT, 4'd0);
        // Codes above the tick are not events
        for (c = wtc_pkg::FUNC_TICK + 1; c < 8; c++)
            send_event(wtc_pkg::func_t'(c), wtc_pkg::BEEP_SUB_RST);
    endtask

    task automatic test_countdown_flow();
        send_event(wtc_pkg::FUNC_INC, 4'd0);
        send_event(wtc_pkg::FUNC_INC, 4'd0);
        send_event(wtc_pkg::FUNC_DEC, 4'd0);
        send_event(wtc_pkg::FUNC_DEC, 4'd0);
        // Below one step: decrement and start do nothing
        send_event(wtc_pkg::FUNC_DEC, 4'd0);
        send_event(wtc_pkg::FUNC_START, 4'd0);
        send_event(wtc_pkg::FUNC_INC, 4'd0);
        send_event(wtc_pkg::FUNC_START, 4'd0);
        send_event(wtc_pkg::FUNC_TICK, 4'd0);
        send_event(wtc_pkg::FUNC_TICK, wtc_pkg::COUNT_SUB_RST);
        send_event(wtc_pkg::FUNC_START, 4'd0);
        send_event(wtc_pkg::FUNC_DEC, 4'd0);
        send_event(wtc_pkg::FUNC_INC, 4'd0);
        send_event(wtc_pkg::FUNC_START, 4'd0);
        send_event(wtc_pkg::FUNC_ABORT, 4'd0);
    endtask

    task automatic test_zero_settings();
        // Upper data bits must be dropped by the narrower registers
        write_all(12'd0, 12'hAF0, 12'hFFF, 12'hF00);
        send_event(wtc_pkg::FUNC_START, 4'd0);
        send_event(wtc_pkg::FUNC_TICK, 4'd3);
        send_event(wtc_pkg::FUNC_INC, 4'd0);
        send_event(wtc_pkg::FUNC_START, 4'd0);
        send_event(wtc_pkg::FUNC_TICK, 4'd15);
        send_event(wtc_pkg::FUNC_TICK, 4'd0);
    endtask

    task automatic test_random_traffic();
        cfg_data_t      st;
        cfg_data_t      bs;
        cfg_data_t      cs;
        cfg_data_t      hd;
        int             p;
        int             n;
        wtc_pkg::func_t f;
        sub_t           sub;
        for (p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    st = cfg_data_t'(wtc_pkg::STEP_RST);
                    bs = cfg_data_t'(wtc_pkg::BEEP_SUB_RST);
                    cs = cfg_data_t'(wtc_pkg::COUNT_SUB_RST);
                    hd = cfg_data_t'(wtc_pkg::STAT_HOLD_RST);
                end
                1: begin st = 12'd1;    bs = 12'd0;  cs = 12'd15; hd = 12'd1;   end
                2: begin st = 12'd4095; bs = 12'd15; cs = 12'd0;  hd = 12'd6;   end
                3: begin st = 12'd0;    bs = 12'd7;  cs = 12'd7;  hd = 12'd0;   end
                4: begin st = 12'd3600; bs = 12'd3;  cs = 12'd12; hd = 12'd255; end
                5: begin
                    st = cfg_data_t'($urandom_range(1, 20));
                    bs = cfg_data_t'($urandom_range(0, 4095));
                    cs = cfg_data_t'($urandom_range(0, 4095));
                    hd = cfg_data_t'($urandom_range(1, 8));
                end
                6: begin
                    st = cfg_data_t'($urandom_range(0, 4095));
                    bs = cfg_data_t'($urandom_range(0, 4095));
                    cs = cfg_data_t'($urandom_range(0, 4095));
                    hd = cfg_data_t'($urandom_range(0, 4095));
                end
                default: begin
                    st = 12'd2;
                    bs = cfg_data_t'($urandom_range(0, 15));
                    cs = cfg_data_t'($urandom_range(0, 15));
                    hd = 12'd3;
                end
            endcase
            long_sets = (p == 2);
            quiet     = (p == 1 || p == 5);
            write_all(st, bs, cs, hd);
            for (n = 0; n < PHASE_QUOTA; n++) begin
                pick_event(f, sub);
                send_event(f, sub);
                if ($urandom_range(0, 99) == 0)
                    settle();
            end
        end
        quiet     = 1'b0;
        long_sets = 1'b0;
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_func        = wtc_pkg::FUNC_INC;
        s_sub_tick    = '0;
        cfg_valid     = 1'b0;
        cfg_index     = wtc_pkg::CFG_STEP;
        cfg_data      = '0;
        quiet         = 1'b0;
        long_sets     = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        events_sent   = 0;
        mode_changes  = 0;
        beeps_due     = 0;
        settings_used = 1;
        cycle_count   = 0;
        reset_timer_model();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_events();
        test_countdown_flow();
        test_zero_settings();
        test_random_traffic();
        settle();

        $display("Covered %0d events in all five modes over %0d register settings",
                 events_sent, settings_used);
        $display("Checked %0d results: %0d mode changes, %0d beeps, %0d mismatches",
                 results_seen, mode_changes, beeps_due, mismatches);
        if (mismatches == 0 && due_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
